// ===== src/utf8s_pkg.sv =====
// Package for the UTF-8 sanitizer: constants, the lead-byte classifier, and the
// types that carry a group of result items from the step logic to the output queue.
// No dependencies.
package utf8s_pkg;

    localparam logic [7:0] QMARK = 8'h3F;

    // Most result items that one input item can cause.
    localparam int GRP_MAX   = 4;
    localparam int GRP_CNT_W = $clog2(GRP_MAX + 1);

    // Output queue depth; must be at least GRP_MAX and a power of two.
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef enum logic [2:0] {
        LEAD_ONE,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } lead_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       valid;
    } ent_t;

    typedef struct packed {
        logic [GRP_CNT_W-1:0]  cnt;
        ent_t [GRP_MAX-1:0]    ent;
    } grp_t;

    // Classifies a byte by its bit structure when it starts a code point.
    // Continuation bytes and 0xF8-0xFF cannot start one.
    function automatic lead_t lead_class(input logic [7:0] b);
        lead_t cls;
        case (b) inside
            [8'h00:8'h7F]: cls = LEAD_ONE;
            [8'hC0:8'hDF]: cls = LEAD_TWO;
            [8'hE0:8'hEF]: cls = LEAD_THREE;
            [8'hF0:8'hF7]: cls = LEAD_FOUR;
            default:       cls = LEAD_BAD;
        endcase
        return cls;
    endfunction

endpackage

// ===== src/utf8s_fifo.sv =====
// Output queue of the UTF-8 sanitizer: takes a group of up to GRP_MAX items in
// one cycle, hands them out one per cycle unless stalled. Depends on utf8s_pkg.
module utf8s_fifo
    import utf8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  grp_t       grp,
    output logic       room,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       text_valid
);

    ent_t             ent_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] wr_cnt;
    logic             rd_en;

    assign rd_en     = out_valid && !out_stall;
    assign wr_cnt    = wr_en ? CNT_W'(grp.cnt) : '0;
    assign room      = cnt_reg <= CNT_W'(FIFO_DEPTH - GRP_MAX);
    assign out_valid = cnt_reg != '0;

    assign out_byte   = ent_reg[rd_ptr_reg].byte_val;
    assign out_last   = ent_reg[rd_ptr_reg].last;
    assign text_valid = ent_reg[rd_ptr_reg].valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(rd_en);
        cnt_next    = cnt_reg + wr_cnt - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < GRP_MAX; i++)
        begin
            if (wr_en && (GRP_CNT_W'(i) < grp.cnt))
            begin
                ent_reg[wr_ptr_reg + PTR_W'(i)] <= grp.ent[i];
            end
        end
    end

endmodule

// ===== src/utf8_sanitizer.sv =====
// Top level of the UTF-8 sanitizer: per-byte step logic and held code point state.
// Depends on utf8s_pkg and utf8s_fifo.
module utf8_sanitizer
    import utf8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       text_valid
);

    // The block repairs a UTF-8 text given one byte per input item, in_last
    // marking the final byte. Lead bytes are judged by their bit pattern only
    // (overlong forms and surrogates pass). A complete code point leaves the
    // block unchanged once its last continuation byte arrives; a stray
    // continuation byte, a byte from 0xF8 to 0xFF, or a code point broken by a
    // non-continuation byte or by the end of the text comes out as '?' (0x3F),
    // one per byte. Every input byte yields exactly one output item in all,
    // though an item that completes a code point releases up to four at once.
    // The final output item carries out_last and, in text_valid, whether no
    // byte of the text was replaced. An input item is taken in every cycle
    // while the output queue has room: the step logic is a single pass from
    // the item to that eight-entry queue, which drains one item per cycle
    // unless stalled. The input side stalls only while that queue holds more
    // than four items, which happens only when the output side stalls.

    logic [7:0] held_bytes_reg [3];
    logic [1:0] held_cnt_reg;
    logic [1:0] held_cnt_next;
    logic [1:0] need_cnt_reg;
    logic [1:0] need_cnt_next;
    logic       saw_inv_reg;
    logic       saw_inv_next;

    logic       in_fire;
    logic       room;
    logic       is_cont;
    lead_t      cls;
    logic       do_fresh;
    logic       inv;
    logic       hold_wr;
    logic       lead_wr;
    logic [1:0] a_cnt;
    logic       a_data;
    logic       b_vld;
    logic [7:0] b_byte;
    logic [1:0] c_cnt;
    logic [1:0] a_end;
    grp_t       grp;

    assign in_stall = !room;
    assign in_fire  = in_valid && !in_stall;
    assign is_cont  = in_byte[7:6] == 2'b10;
    assign cls      = lead_class(in_byte);

    // One step of the repair. The results of a step are, in order: the bytes
    // that were held (as data when the code point completes, as '?' when it is
    // broken), then one byte for the input itself when it is not held, then
    // one '?' for every byte still held when the text ends.
    always_comb
    begin
        do_fresh      = 1'b0;
        inv           = 1'b0;
        hold_wr       = 1'b0;
        lead_wr       = 1'b0;
        a_cnt         = 2'd0;
        a_data        = 1'b0;
        b_vld         = 1'b0;
        b_byte        = in_byte;
        held_cnt_next = held_cnt_reg;
        need_cnt_next = need_cnt_reg;

        if (held_cnt_reg == 2'd0)
        begin
            do_fresh = 1'b1;
        end
        else if (is_cont)
        begin
            if (need_cnt_reg <= 2'd1)
            begin
                // Code point complete: release it unchanged.
                a_cnt         = held_cnt_reg;
                a_data        = 1'b1;
                b_vld         = 1'b1;
                held_cnt_next = 2'd0;
                need_cnt_next = 2'd0;
            end
            else if (held_cnt_reg != 2'd3)
            begin
                hold_wr       = 1'b1;
                held_cnt_next = held_cnt_reg + 2'd1;
                need_cnt_next = need_cnt_reg - 2'd1;
            end
            else
            begin
                // No room left to hold; cannot arise from a legal lead.
                a_cnt         = 2'd3;
                b_vld         = 1'b1;
                b_byte        = QMARK;
                inv           = 1'b1;
                held_cnt_next = 2'd0;
                need_cnt_next = 2'd0;
            end
        end
        else
        begin
            // Broken sequence: held bytes become '?', the byte starts afresh.
            a_cnt         = held_cnt_reg;
            inv           = 1'b1;
            held_cnt_next = 2'd0;
            need_cnt_next = 2'd0;
            do_fresh      = 1'b1;
        end

        if (do_fresh)
        begin
            case (cls)
                LEAD_ONE:
                begin
                    b_vld = 1'b1;
                end
                LEAD_TWO:
                begin
                    lead_wr       = 1'b1;
                    held_cnt_next = 2'd1;
                    need_cnt_next = 2'd1;
                end
                LEAD_THREE:
                begin
                    lead_wr       = 1'b1;
                    held_cnt_next = 2'd1;
                    need_cnt_next = 2'd2;
                end
                LEAD_FOUR:
                begin
                    lead_wr       = 1'b1;
                    held_cnt_next = 2'd1;
                    need_cnt_next = 2'd3;
                end
                default:
                begin
                    b_vld  = 1'b1;
                    b_byte = QMARK;
                    inv    = 1'b1;
                end
            endcase
        end

        // Text ends with a code point still open: flush it as '?'.
        c_cnt = in_last ? held_cnt_next : 2'd0;
        if (c_cnt != 2'd0)
        begin
            inv = 1'b1;
        end

        saw_inv_next = saw_inv_reg | inv;

        if (in_last)
        begin
            held_cnt_next = 2'd0;
            need_cnt_next = 2'd0;
            saw_inv_next  = 1'b0;
        end
    end

    // Lay the results out as a group for the output queue.
    assign a_end = a_cnt;

    always_comb
    begin
        grp.cnt = GRP_CNT_W'(a_cnt) + GRP_CNT_W'(b_vld) + GRP_CNT_W'(c_cnt);
        for (int i = 0; i < GRP_MAX; i++)
        begin
            if (GRP_CNT_W'(i) < GRP_CNT_W'(a_end))
            begin
                grp.ent[i].byte_val = a_data ? held_bytes_reg[2'(i % 3)] : QMARK;
            end
            else if (b_vld && (GRP_CNT_W'(i) == GRP_CNT_W'(a_end)))
            begin
                grp.ent[i].byte_val = b_byte;
            end
            else
            begin
                grp.ent[i].byte_val = QMARK;
            end
            grp.ent[i].last  = in_last && (GRP_CNT_W'(i + 1) == grp.cnt);
            grp.ent[i].valid = in_last && (GRP_CNT_W'(i + 1) == grp.cnt) && !(saw_inv_reg | inv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            need_cnt_reg <= 2'd0;
            saw_inv_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            held_cnt_reg <= held_cnt_next;
            need_cnt_reg <= need_cnt_next;
            saw_inv_reg  <= saw_inv_next;
        end
    end

    // Held bytes are payload: only entries below the held count are read.
    always_ff @(posedge clk)
    begin
        if (in_fire && lead_wr)
        begin
            held_bytes_reg[0] <= in_byte;
        end
        else if (in_fire && hold_wr)
        begin
            held_bytes_reg[held_cnt_reg] <= in_byte;
        end
    end

    utf8s_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (in_fire),
        .grp        (grp),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .text_valid (text_valid)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the UTF-8 sanitizer: drives byte texts through the
// valid/stall input, predicts the repaired stream and checks every output item.
// Depends on utf8s_pkg (lead_t, QMARK) and the utf8_sanitizer RTL.
module testbench
    import utf8s_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped if no item moves on either side for this many cycles.
    localparam int STUCK_LIMIT  = 2000;
    // Cycles allowed after the last expected item, to catch stray extra items.
    localparam int DRAIN_CYCLES = 20;
    // Number of input items to generate at least; a text may run past it.
    localparam int ITEM_TARGET  = 330;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES  = 80;
    // Printed error lines are capped so a badly broken block cannot flood the log.
    localparam int PRINT_CAP    = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } raw_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       whole_ok;
    } clean_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    logic       text_valid;

    // Raw text bytes waiting to be offered, and sanitized bytes still expected.
    raw_item_t   raw_text_q[$];
    clean_item_t clean_q[$];
    clean_item_t step_q[$];

    // Shadow of the sanitizer state: the partial code point and the text status.
    logic [7:0] held_q[3];
    int         held_n = 0;
    int         need_n = 0;
    logic       bad_seen = 1'b0;

    int  err_n = 0;
    int  sent_n = 0;
    int  got_n = 0;
    int  idle_run = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;

    utf8_sanitizer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .text_valid (text_valid)
    );

    always #5 clk = ~clk;

    task automatic report_error(input string what);
        if (err_n < PRINT_CAP)
        begin
            $display("ERROR @%0t: %s", $time, what);
        end
        err_n++;
    endtask

    // Classifies a byte as the start of a code point, from its top bits alone.
    function automatic lead_t lead_kind(input logic [7:0] b);
        if (b[7] == 1'b0)
        begin
            return LEAD_ONE;
        end
        if ((b & 8'hE0) == 8'hC0)
        begin
            return LEAD_TWO;
        end
        if ((b & 8'hF0) == 8'hE0)
        begin
            return LEAD_THREE;
        end
        if ((b & 8'hF8) == 8'hF0)
        begin
            return LEAD_FOUR;
        end
        return LEAD_BAD;
    endfunction

    task automatic emit_clean(input logic [7:0] b);
        clean_item_t item;
        item.data = b;
        item.last = 1'b0;
        item.whole_ok = 1'b0;
        step_q.push_back(item);
    endtask

    // A held code point that cannot complete turns into one '?' per held byte.
    task automatic drop_held();
        int k;
        for (k = 0; k < held_n; k++)
        begin
            emit_clean(QMARK);
        end
        if (held_n != 0)
        begin
            bad_seen = 1'b1;
        end
        held_n = 0;
        need_n = 0;
    endtask

    // Handles a byte that arrives with nothing held.
    task automatic start_point(input logic [7:0] b);
        lead_t kind;
        kind = lead_kind(b);
        case (kind)
            LEAD_ONE:
            begin
                emit_clean(b);
            end
            LEAD_BAD:
            begin
                emit_clean(QMARK);
                bad_seen = 1'b1;
            end
            default:
            begin
                held_q[0] = b;
                held_n = 1;
                need_n = (kind == LEAD_TWO) ? 1 : (kind == LEAD_THREE) ? 2 : 3;
            end
        endcase
    endtask

    // Works out the sanitized items that one accepted text byte releases and
    // appends them to the expected stream.
    task automatic sanitize_step(input logic [7:0] b, input logic last);
        int k;
        clean_item_t tail;
        step_q.delete();
        if (held_n == 0)
        begin
            start_point(b);
        end
        else if (b[7:6] == 2'b10)
        begin
            if (need_n <= 1)
            begin
                // The code point is complete and leaves unchanged.
                for (k = 0; k < held_n; k++)
                begin
                    emit_clean(held_q[k]);
                end
                emit_clean(b);
                held_n = 0;
                need_n = 0;
            end
            else
            begin
                held_q[held_n] = b;
                held_n++;
                need_n--;
            end
        end
        else
        begin
            // A broken sequence: flush the held bytes, then treat the
            // breaking byte as a new lead within the same item.
            drop_held();
            start_point(b);
        end
        if (last)
        begin
            // A code point cut short by the end of the text is flushed too,
            // and the final item carries the verdict for the whole text.
            drop_held();
            if (step_q.size() > 0)
            begin
                tail = step_q[step_q.size() - 1];
                tail.last = 1'b1;
                tail.whole_ok = !bad_seen;
                step_q[step_q.size() - 1] = tail;
            end
            bad_seen = 1'b0;
            held_n = 0;
            need_n = 0;
        end
        for (k = 0; k < step_q.size(); k++)
        begin
            clean_q.push_back(step_q[k]);
        end
    endtask

    task automatic add_item(input logic [7:0] b, input logic last);
        raw_item_t item;
        item.data = b;
        item.last = last;
        raw_text_q.push_back(item);
    endtask

    // Builds one random text. Most code points are well formed with random
    // payload bits; the rest are truncated sequences or arbitrary bytes.
    task automatic add_random_text();
        raw_item_t part[$];
        raw_item_t item;
        int cps;
        int r;
        int kind;
        int extra;
        int i;
        int j;
        logic [7:0] lead;
        cps = $urandom_range(1, 6);
        for (i = 0; i < cps; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 90)
            begin
                kind = (r < 80) ? $urandom_range(0, 3) : $urandom_range(1, 3);
                case (kind)
                    0:       lead = 8'($urandom_range(0, 127));
                    1:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                    2:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                    default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                extra = (r < 80) ? kind : $urandom_range(0, kind - 1);
                item.data = lead;
                item.last = 1'b0;
                part.push_back(item);
                for (j = 0; j < extra; j++)
                begin
                    item.data = 8'h80 | 8'($urandom_range(0, 63));
                    part.push_back(item);
                end
            end
            else
            begin
                item.data = 8'($urandom_range(0, 255));
                item.last = 1'b0;
                part.push_back(item);
            end
        end
        for (j = 0; j < part.size(); j++)
        begin
            add_item(part[j].data, j == part.size() - 1);
        end
    endtask

    // Sender: offers the next raw byte unless it idles. A stalled item is held
    // unchanged, and valid is never lowered because of stall.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                void'(raw_text_q.pop_front());
            end
            // A stretch of items goes in with no idling at all.
            if (raw_text_q.size() > 0 &&
                ((sent_n >= 230 && sent_n < 300) || $urandom_range(0, 99) >= 19))
            begin
                in_valid <= 1'b1;
                in_byte <= raw_text_q[0].data;
                in_last <= raw_text_q[0].last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, a calm stretch, and one long hold-off while the
    // sender keeps offering, so the output queue fills and the input stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (got_n >= 200 && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (got_n >= 40 && got_n < 120)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 19);
        end
    end

    // Monitor: predicts from each accepted input item first, then checks the output;
    // a result is offered only from the output queue, after its input was accepted.
    always @(posedge clk)
    begin
        clean_item_t want;
        logic moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sanitize_step(in_byte, in_last);
                sent_n <= sent_n + 1;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got_n <= got_n + 1;
                if (clean_q.size() == 0)
                begin
                    report_error($sformatf("unexpected item byte=%02h last=%0b valid=%0b",
                                           out_byte, out_last, text_valid));
                end
                else
                begin
                    want = clean_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        report_error($sformatf("item %0d: out_byte %02h, expected %02h",
                                               got_n, out_byte, want.data));
                    end
                    if (out_last !== want.last)
                    begin
                        report_error($sformatf("item %0d: out_last %0b, expected %0b",
                                               got_n, out_last, want.last));
                    end
                    if (text_valid !== want.whole_ok)
                    begin
                        report_error($sformatf("item %0d: text_valid %0b, expected %0b",
                                               got_n, text_valid, want.whole_ok));
                    end
                end
            end
            idle_run <= moved ? 0 : idle_run + 1;
        end
    end

    initial
    begin
        logic timed_out;
        timed_out = 1'b0;

        // Directed texts. Plain ASCII extremes and one code point of each
        // length make a valid text.
        add_item(8'h00, 1'b0);
        add_item(8'h7F, 1'b0);
        add_item(8'hC2, 1'b0);
        add_item(8'hA9, 1'b0);
        add_item(8'hE2, 1'b0);
        add_item(8'h82, 1'b0);
        add_item(8'hAC, 1'b0);
        add_item(8'hF0, 1'b0);
        add_item(8'h9F, 1'b0);
        add_item(8'h98, 1'b0);
        add_item(8'h80, 1'b1);
        // Stray continuation and the two ends of the bad lead range.
        add_item(8'h80, 1'b0);
        add_item(8'hF8, 1'b0);
        add_item(8'hFF, 1'b1);
        // A three-byte point broken by an ASCII byte.
        add_item(8'hE2, 1'b0);
        add_item(8'h82, 1'b0);
        add_item(8'h41, 1'b1);
        // A four-byte point cut short by the end of the text.
        add_item(8'hF0, 1'b0);
        add_item(8'h9F, 1'b1);
        // A lone two-byte lead as a whole text.
        add_item(8'hC3, 1'b1);
        // A one-byte text.
        add_item(8'h41, 1'b1);
        // A lead broken by another lead that then completes.
        add_item(8'hC3, 1'b0);
        add_item(8'hE2, 1'b0);
        add_item(8'h82, 1'b0);
        add_item(8'hAC, 1'b1);
        // Three held bytes broken by an ASCII byte: four items from one byte.
        add_item(8'hF7, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'h7E, 1'b1);

        while (raw_text_q.size() < ITEM_TARGET)
        begin
            add_random_text();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every byte went in and every expected item came out.
        while (!timed_out &&
               !(raw_text_q.size() == 0 && !in_valid && clean_q.size() == 0))
        begin
            @(posedge clk);
            if (idle_run >= STUCK_LIMIT)
            begin
                timed_out = 1'b1;
            end
        end
        if (!timed_out)
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        if (clean_q.size() != 0)
        begin
            report_error($sformatf("%0d expected items never came out", clean_q.size()));
        end

        if (timed_out)
        begin
            $display("*** FAILED ***");
        end
        else if (err_n == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/utf8s_pkg.sv
src/utf8s_fifo.sv
src/utf8_sanitizer.sv
tb/sv/testbench.sv
